// ----- design/ctb_pkg.sv -----
// ---------------------------------------------------------------------------
// ctb_pkg
// Shared constants and types for the Cartesian tree builder.
// ---------------------------------------------------------------------------
`default_nettype none

package ctb_pkg;

   localparam int MAX_NODES  = 1024;
   localparam int VALUE_BITS = 32;
   localparam int IDX_W      = $clog2(MAX_NODES);
   localparam int PTR_W      = $clog2(MAX_NODES + 1);

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         first;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] node_index;
      logic [IDX_W-1:0] left_child;
      logic             has_left;
      logic [IDX_W-1:0] parent;
      logic             has_parent;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0]             idx;
      logic signed [VALUE_BITS-1:0] value;
   } entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } ram_req_type;

endpackage

`default_nettype wire

// ----- design/ctb_stack_ram.sv -----
// ---------------------------------------------------------------------------
// ctb_stack_ram
// Stack storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ctb_stack_ram (
   input  wire logic                clock,
   input  wire ctb_pkg::ram_req_type ram_req,
   output      ctb_pkg::entry_type  rd_data
);

   ctb_pkg::entry_type mem [ctb_pkg::MAX_NODES];
   ctb_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/ctb_ctrl.sv -----
// ---------------------------------------------------------------------------
// ctb_ctrl
// Stack sequencer: pops entries with greater keys, then pushes the new node.
// ---------------------------------------------------------------------------
`default_nettype none

module ctb_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire ctb_pkg::req_type     req_data,
   input  wire logic                 out_free,
   output      logic                 rsp_load,
   output      ctb_pkg::rsp_type     rsp_next,
   output      ctb_pkg::ram_req_type ram_req,
   input  wire ctb_pkg::entry_type   rd_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_CMP  = 1'b1;

   logic                                  state_ff, state_in;
   logic [ctb_pkg::PTR_W-1:0]             top_ff, top_in;
   logic [ctb_pkg::PTR_W-1:0]             next_ff, next_in;
   logic                                  skip_ff, skip_in;
   logic                                  ovf_ff, ovf_in;
   logic                                  popped_ff, popped_in;
   logic [ctb_pkg::IDX_W-1:0]             child_ff, child_in;
   logic [ctb_pkg::IDX_W-1:0]             idx_ff, idx_in;
   logic signed [ctb_pkg::VALUE_BITS-1:0] key_ff, key_in;

   logic [ctb_pkg::PTR_W-1:0] eff_top, eff_next, top_dec;
   logic                      accept, greater;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign eff_top   = req_data.first ? '0 : top_ff;
   assign eff_next  = req_data.first ? '0 : next_ff;
   assign top_dec   = top_ff - 1'b1;
   assign greater   = $signed(rd_data.value) > $signed(key_ff);

   always_comb begin
      state_in  = state_ff;
      top_in    = top_ff;
      next_in   = next_ff;
      skip_in   = skip_ff;
      ovf_in    = ovf_ff;
      popped_in = popped_ff;
      child_in  = child_ff;
      idx_in    = idx_ff;
      key_in    = key_ff;
      rsp_load  = 1'b0;
      rsp_next  = '0;
      ram_req   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ovf_in          = (eff_next >= ctb_pkg::PTR_W'(ctb_pkg::MAX_NODES))
                              || (eff_top >= ctb_pkg::PTR_W'(ctb_pkg::MAX_NODES));
               skip_in         = ovf_in || (eff_top == '0);
               top_in          = eff_top;
               next_in         = eff_next;
               idx_in          = eff_next[ctb_pkg::IDX_W-1:0];
               key_in          = req_data.value;
               popped_in       = 1'b0;
               child_in        = '0;
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = ctb_pkg::IDX_W'(eff_top - 1'b1);
               state_in        = ST_CMP;
            end
         end
         ST_CMP: begin
            if (!skip_ff && greater) begin
               top_in    = top_dec;
               child_in  = rd_data.idx;
               popped_in = 1'b1;
               if (top_dec == '0) begin
                  skip_in = 1'b1;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = ctb_pkg::IDX_W'(top_dec - 1'b1);
               end
            end else if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (ovf_ff) begin
                  rsp_next.overflow = 1'b1;
               end else begin
                  rsp_next.node_index = idx_ff;
                  rsp_next.left_child = child_ff;
                  rsp_next.has_left   = popped_ff;
                  rsp_next.parent     = skip_ff ? '0 : rd_data.idx;
                  rsp_next.has_parent = !skip_ff;
                  ram_req.wr_en       = 1'b1;
                  ram_req.wr_addr     = top_ff[ctb_pkg::IDX_W-1:0];
                  ram_req.wr_data.idx   = idx_ff;
                  ram_req.wr_data.value = key_ff;
                  top_in  = top_ff + 1'b1;
                  next_in = next_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         top_ff    <= '0;
         next_ff   <= '0;
         skip_ff   <= 1'b0;
         ovf_ff    <= 1'b0;
         popped_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         top_ff    <= top_in;
         next_ff   <= next_in;
         skip_ff   <= skip_in;
         ovf_ff    <= ovf_in;
         popped_ff <= popped_in;
      end
      child_ff <= child_in;
      idx_ff   <= idx_in;
      key_ff   <= key_in;
   end

   a_top_le_next: assert property (@(posedge clock) disable iff (reset)
      top_ff <= next_ff)
      else $error("stack deeper than node count");

   a_cmp_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP && !skip_ff) |-> (top_ff != '0))
      else $error("compare against empty stack");

   a_no_push_on_ovf: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> (!ovf_ff && rsp_load))
      else $error("push without a result");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result loaded while output busy");

endmodule

`default_nettype wire

// ----- design/cartesian_tree_builder.sv -----
// ---------------------------------------------------------------------------
// cartesian_tree_builder
// Streaming min Cartesian tree construction, one update record per value.
// ---------------------------------------------------------------------------
// Each accepted beat reads the stack top and pops every entry with a greater
// key (amortized under one pop per beat); the loop is one read of the stack
// memory and one key compare per cycle. Results leave through an output
// register, so a new beat is taken while a result waits on rsp_ready.
`default_nettype none

module cartesian_tree_builder (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire ctb_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      ctb_pkg::rsp_type rsp_data
);

   ctb_pkg::ram_req_type ram_req;
   ctb_pkg::entry_type   rd_data;
   ctb_pkg::rsp_type     rsp_next;
   ctb_pkg::rsp_type     rsp_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_load, out_free;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   ctb_stack_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   ctb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_free  (out_free),
      .rsp_load  (rsp_load),
      .rsp_next  (rsp_next),
      .ram_req   (ram_req),
      .rd_data   (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- verif/tb_cartesian_tree_builder.sv -----
// ---------------------------------------------------------------------------
// tb_cartesian_tree_builder
// Self-checking bench for the streaming min Cartesian tree builder.
// ---------------------------------------------------------------------------
// A table of directed beats covers the value extremes, ties, a start with no
// first flag, and restarts. Random sequences follow, with one run past
// capacity that includes a deep pop. A local copy of the spine stack predicts
// each unpinned update record. Both channels stall at random outside a steady run.
`default_nettype none

module tb_cartesian_tree_builder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_BEATS = 1500;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 40;
   localparam int N_PROBES     = 18;

   typedef struct {
      ctb_pkg::req_type req;
      bit               pinned;
      ctb_pkg::rsp_type rec;
   } probe_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ctb_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ctb_pkg::rsp_type rsp_data;

   // spine of the tree so far, bottom entry at depth 0
   logic [ctb_pkg::IDX_W-1:0]             spine_index [ctb_pkg::MAX_NODES];
   logic signed [ctb_pkg::VALUE_BITS-1:0] spine_key   [ctb_pkg::MAX_NODES];
   int                                    spine_depth = 0;
   int                                    seq_len     = 0;

   ctb_pkg::rsp_type pending_records [$];
   int               mismatches     = 0;
   int               beats_sent     = 0;
   int               stalled_cycles = 0;
   bit               steady         = 1'b0;

   probe_row_type probes [N_PROBES] = '{
      '{'{32'sd0,            1'b0}, 1'b1, '{10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 1'b0}},
      '{'{32'sh7fff_ffff,    1'b0}, 1'b1, '{10'd1, 10'd0, 1'b0, 10'd0, 1'b1, 1'b0}},
      '{'{32'sh8000_0000,    1'b0}, 1'b1, '{10'd2, 10'd0, 1'b1, 10'd0, 1'b0, 1'b0}},
      '{'{32'sh8000_0000,    1'b0}, 1'b1, '{10'd3, 10'd0, 1'b0, 10'd2, 1'b1, 1'b0}},
      '{'{32'shffff_ffff,    1'b0}, 1'b1, '{10'd4, 10'd0, 1'b0, 10'd3, 1'b1, 1'b0}},
      '{'{32'sh7fff_ffff,    1'b0}, 1'b1, '{10'd5, 10'd0, 1'b0, 10'd4, 1'b1, 1'b0}},
      '{'{32'sd0,            1'b0}, 1'b1, '{10'd6, 10'd5, 1'b1, 10'd4, 1'b1, 1'b0}},
      '{'{32'sh5555_5555,    1'b1}, 1'b1, '{10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 1'b0}},
      '{'{32'shaaaa_aaaa,    1'b0}, 1'b1, '{10'd1, 10'd0, 1'b1, 10'd0, 1'b0, 1'b0}},
      '{'{32'sh5555_5555,    1'b0}, 1'b0, '0},
      '{'{32'sd1,            1'b0}, 1'b0, '0},
      '{'{32'sd2,            1'b0}, 1'b0, '0},
      '{'{32'sd3,            1'b0}, 1'b0, '0},
      '{'{-32'sd5,           1'b0}, 1'b0, '0},
      '{'{32'sd3,            1'b0}, 1'b0, '0},
      '{'{32'sd3,            1'b0}, 1'b0, '0},
      '{'{32'sd1,            1'b1}, 1'b1, '{10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 1'b0}},
      '{'{32'shffff_fffe,    1'b0}, 1'b0, '0}
   };

   cartesian_tree_builder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic ctb_pkg::rsp_type place_node(ctb_pkg::req_type r);
      ctb_pkg::rsp_type rec;
      rec = '0;
      if (r.first) begin
         spine_depth = 0;
         seq_len     = 0;
      end
      if (seq_len >= ctb_pkg::MAX_NODES || spine_depth >= ctb_pkg::MAX_NODES) begin
         rec.overflow = 1'b1;
         return rec;
      end
      rec.node_index = seq_len[ctb_pkg::IDX_W-1:0];
      while (spine_depth > 0 && $signed(spine_key[spine_depth-1]) > $signed(r.value)) begin
         spine_depth--;
         rec.left_child = spine_index[spine_depth];
         rec.has_left   = 1'b1;
      end
      if (spine_depth > 0) begin
         rec.parent     = spine_index[spine_depth-1];
         rec.has_parent = 1'b1;
      end
      spine_index[spine_depth] = seq_len[ctb_pkg::IDX_W-1:0];
      spine_key[spine_depth]   = r.value;
      spine_depth++;
      seq_len++;
      return rec;
   endfunction

   task automatic send_beat(input ctb_pkg::req_type r, input bit pinned,
                            input ctb_pkg::rsp_type rec);
      ctb_pkg::rsp_type predicted;
      while (!steady && $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = place_node(r);
      pending_records.push_back(pinned ? rec : predicted);
      beats_sent++;
      steady <= (beats_sent >= 600 && beats_sent < 900);
   endtask

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 37);
   end

   always @(posedge clock) begin
      ctb_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_records.size() == 0) begin
            $error("result beat with no record pending");
            mismatches++;
         end else begin
            want = pending_records.pop_front();
            if (rsp_data.node_index !== want.node_index) begin
               $error("node_index: expected %0d, got %0d", want.node_index, rsp_data.node_index);
               mismatches++;
            end
            if (rsp_data.left_child !== want.left_child) begin
               $error("left_child: expected %0d, got %0d", want.left_child, rsp_data.left_child);
               mismatches++;
            end
            if (rsp_data.has_left !== want.has_left) begin
               $error("has_left: expected %0d, got %0d", want.has_left, rsp_data.has_left);
               mismatches++;
            end
            if (rsp_data.parent !== want.parent) begin
               $error("parent: expected %0d, got %0d", want.parent, rsp_data.parent);
               mismatches++;
            end
            if (rsp_data.has_parent !== want.has_parent) begin
               $error("has_parent: expected %0d, got %0d", want.has_parent, rsp_data.has_parent);
               mismatches++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $error("overflow: expected %0d, got %0d", want.overflow, rsp_data.overflow);
               mismatches++;
            end
         end
      end
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
      end
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      ctb_pkg::req_type r;
      int               seq_left;
      int               mode;
      int               level;
      bit               long_done;
      long_done = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_PROBES; i++) begin
         send_beat(probes[i].req, probes[i].pinned, probes[i].rec);
      end

      while (beats_sent < RANDOM_BEATS) begin
         if (!long_done && beats_sent >= 300) begin
            // fill to capacity, one deep pop near the end, then dropped beats
            long_done = 1'b1;
            for (int k = 0; k < ctb_pkg::MAX_NODES + 8; k++) begin
               r.first = (k == 0);
               if (k == 1000) begin
                  r.value = 32'sh8000_0000;
               end else if (k >= ctb_pkg::MAX_NODES) begin
                  r.value = $urandom;
               end else begin
                  r.value = k * 4 - 2000 + $urandom_range(0, 3);
               end
               send_beat(r, 1'b0, '0);
            end
         end else begin
            mode     = $urandom_range(0, 3);
            seq_left = $urandom_range(1, 40);
            level    = $urandom;
            for (int pos = 0; pos < seq_left; pos++) begin
               if (pos == 0) begin
                  r.first = ($urandom_range(0, 9) != 0);
               end else begin
                  r.first = ($urandom_range(0, 49) == 0);
               end
               case (mode)
                  0: begin
                     r.value = $urandom;
                  end
                  1: begin
                     r.value = $urandom_range(0, 6) - 3;
                  end
                  2: begin
                     level = level + $urandom_range(0, 50);
                     if ($urandom_range(0, 7) == 0) level = level - $urandom_range(0, 400);
                     r.value = level;
                  end
                  default: begin
                     level = level - $urandom_range(0, 50);
                     if ($urandom_range(0, 7) == 0) level = level + $urandom_range(0, 400);
                     r.value = level;
                  end
               endcase
               send_beat(r, 1'b0, '0);
            end
         end
      end
      req_valid <= 1'b0;

      while (pending_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
design/ctb_pkg.sv
design/ctb_stack_ram.sv
design/ctb_ctrl.sv
design/cartesian_tree_builder.sv
verif/tb_cartesian_tree_builder.sv
